### hw/rtl/efpsg_pkg.sv
// ----------------------------------------------------------------------------
// efpsg_pkg
// Shared widths, register indexes and filter constants for the encoder
// filter, position mapper and servo gate.
// ----------------------------------------------------------------------------
package efpsg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TGT_W      = 18;
	localparam int POS_W      = 19;
	localparam int ERR_W      = 20;
	localparam int MARGIN_W   = 15;
	localparam int TOL_W      = 10;
	localparam int SPEED_W    = 7;
	localparam int TAPS       = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// weighted sum of five 16-bit taps, weights add up to 100
	localparam int SUM_W      = 23;
	localparam int MAG_W      = 22;
	localparam int PROD_W     = 45;
	localparam int RECIP_SHIFT = 29;
	localparam logic [MAG_W:0] RECIP_100 = 23'd5368710;

	localparam logic signed [SUM_W-1:0] W_OLDEST = 23'sd10;
	localparam logic signed [SUM_W-1:0] W_OLD    = 23'sd15;
	localparam logic signed [SUM_W-1:0] W_MID    = 23'sd20;
	localparam logic signed [SUM_W-1:0] W_NEW    = 23'sd25;
	localparam logic signed [SUM_W-1:0] W_NEWEST = 23'sd30;

	localparam int WARMUP_ITEMS_DEF = 6;

	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_MARGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TOL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_SPEED     = 3'd4;

	localparam logic signed [SAMPLE_W-1:0] BOUNDARY_RST = '0;
	localparam logic [MARGIN_W-1:0]        MARGIN_RST   = 15'd10;
	localparam logic [TOL_W-1:0]           TOL_RST      = 10'd2;
	localparam logic [SPEED_W-1:0]         SPEED_RST    = 7'd40;

endpackage

### hw/rtl/encoder_filter_position_servo_gate.sv
// ----------------------------------------------------------------------------
// encoder_filter_position_servo_gate
// Five-tap glitch-rejecting x/y filter, quadrant position mapper and
// stop/run motor command gate.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the output stalls and returns one result
// per request through a five-stage pipeline: input register, history update
// and weighted sum, divide by 100 (reciprocal multiply), quadrant mapping,
// error check into the output register. Throughput is one request per clock
// unless the output stalls, set by the history update, whose accept test
// against the newest tap is combinational. Each stage holds its request when
// the one after it is stalled, so requests keep flowing into empty stages
// while a result waits. The first WARMUP_ITEMS requests issue no command.
// Registers are written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module encoder_filter_position_servo_gate
	import efpsg_pkg::*;
#(
	parameter int WARMUP_ITEMS = WARMUP_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_x,
	input  logic signed [SAMPLE_W-1:0]  sample_y,
	input  logic [TGT_W-1:0]            target_position,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [SAMPLE_W-1:0]  filtered_x,
	output logic signed [SAMPLE_W-1:0]  filtered_y,
	output logic signed [POS_W-1:0]     position,
	output logic                        command_valid,
	output logic [SPEED_W-1:0]          motor_speed,
	output logic                        at_target
);

	localparam int CNT_W = $clog2(WARMUP_ITEMS + 1);

	// configuration
	logic signed [SAMPLE_W-1:0] bnd_lo_q, bnd_hi_q;
	logic [MARGIN_W-1:0]        margin_q;
	logic [TOL_W-1:0]           tol_q;
	logic [SPEED_W-1:0]         speed_q;

	// filter state
	logic signed [SAMPLE_W-1:0] hist_x_q [TAPS];
	logic signed [SAMPLE_W-1:0] hist_y_q [TAPS];
	logic signed [SAMPLE_W-1:0] hist_x_n [TAPS];
	logic signed [SAMPLE_W-1:0] hist_y_n [TAPS];
	logic [CNT_W-1:0]           warm_cnt_q;
	logic                       warmed_q;
	logic [CNT_W-1:0]           warm_cnt_inc;

	// pipeline
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4, en5;
	logic step;

	logic signed [SAMPLE_W-1:0] sx_s1, sy_s1;
	logic [TGT_W-1:0]           tgt_s1, tgt_s2, tgt_s3, tgt_s4;
	logic signed [SUM_W-1:0]    sum_x_s2, sum_y_s2;
	logic signed [SUM_W-1:0]    sum_x_n, sum_y_n;
	logic                       cmd_s2, cmd_s3, cmd_s4;
	logic signed [SAMPLE_W-1:0] fx_s3, fy_s3, fx_s4, fy_s4;
	logic signed [POS_W-1:0]    pos_s4;
	logic signed [ERR_W-1:0]    err;
	logic [ERR_W-1:0]           err_abs;
	logic                       near;

	function automatic logic take_sample(
		input logic signed [SAMPLE_W-1:0] s,
		input logic signed [SAMPLE_W-1:0] h,
		input logic [MARGIN_W-1:0]        m
	);
		logic signed [SAMPLE_W+1:0] ms, mh, d;
		logic [SAMPLE_W+1:0]        da;
		ms = (SAMPLE_W + 2)'(s);
		mh = (SAMPLE_W + 2)'(h);
		if (ms < 0) ms = -ms;
		if (mh < 0) mh = -mh;
		d  = ms - mh;
		da = (d < 0) ? (SAMPLE_W + 2)'(-d) : (SAMPLE_W + 2)'(d);
		return da < (SAMPLE_W + 2)'(m);
	endfunction

	function automatic logic signed [SUM_W-1:0] wsum(
		input logic signed [SAMPLE_W-1:0] h [TAPS]
	);
		return SUM_W'(h[4]) * W_OLDEST + SUM_W'(h[3]) * W_OLD + SUM_W'(h[2]) * W_MID
			+ SUM_W'(h[1]) * W_NEW + SUM_W'(h[0]) * W_NEWEST;
	endfunction

	// truncating divide by 100: exact for magnitudes below 2^22
	function automatic logic signed [SAMPLE_W-1:0] div100(
		input logic signed [SUM_W-1:0] s
	);
		logic [MAG_W-1:0]    mag;
		logic [PROD_W-1:0]   prod;
		logic [SAMPLE_W-1:0] quo;
		mag  = s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
		prod = PROD_W'(mag) * PROD_W'(RECIP_100);
		quo  = prod[RECIP_SHIFT +: SAMPLE_W];
		return s[SUM_W-1] ? SAMPLE_W'(-quo) : quo;
	endfunction

	function automatic logic signed [POS_W-1:0] map_pos(
		input logic signed [SAMPLE_W-1:0] x,
		input logic signed [SAMPLE_W-1:0] y,
		input logic signed [SAMPLE_W-1:0] lo,
		input logic signed [SAMPLE_W-1:0] hi
	);
		logic signed [ERR_W-1:0] xe, ye, le, he, q, alo, r;
		logic                    y_in, x_in, y_above;
		xe      = ERR_W'(x);
		ye      = ERR_W'(y);
		le      = ERR_W'(lo);
		he      = ERR_W'(hi);
		q       = le + he;
		alo     = (le < 0) ? -le : le;
		y_in    = (ye <= he) && (ye >= le);
		x_in    = (xe <= he) && (xe >= le);
		y_above = ye > he;
		if (xe >= he) begin
			r = y_in ? he - ye : (y_above ? '0 : q);
		end else if (ye <= le) begin
			r = x_in ? (he - xe) + q : (y_above ? q : q + q);
		end else if (xe <= le) begin
			r = y_in ? alo + ye + q + q : (y_above ? q + q : q + q + q);
		end else begin
			r = '0;
		end
		return r[POS_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_lo_q <= BOUNDARY_RST;
			bnd_hi_q <= BOUNDARY_RST;
			margin_q <= MARGIN_RST;
			tol_q    <= TOL_RST;
			speed_q  <= SPEED_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BOUNDARY_LOW:  bnd_lo_q <= cfg_data[SAMPLE_W-1:0];
				REG_BOUNDARY_HIGH: bnd_hi_q <= cfg_data[SAMPLE_W-1:0];
				REG_REJECT_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				REG_STOP_TOL:      tol_q    <= cfg_data[TOL_W-1:0];
				REG_RUN_SPEED:     speed_q  <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage advance: a stage loads when it is empty or its successor moves
	assign en5      = !out_valid || out_ready;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;
	assign step     = vld_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) out_valid <= vld_s4;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (en1) begin
			sx_s1  <= sample_x;
			sy_s1  <= sample_y;
			tgt_s1 <= target_position;
		end
	end

	// history shift, newest tap repeats when the sample is rejected
	always_comb begin
		for (int i = 1; i < TAPS; i++) begin
			hist_x_n[i] = hist_x_q[i-1];
			hist_y_n[i] = hist_y_q[i-1];
		end
		hist_x_n[0] = (!warmed_q || take_sample(sx_s1, hist_x_q[0], margin_q)) ?
			sx_s1 : hist_x_q[0];
		hist_y_n[0] = (!warmed_q || take_sample(sy_s1, hist_y_q[0], margin_q)) ?
			sy_s1 : hist_y_q[0];
		sum_x_n = wsum(hist_x_n);
		sum_y_n = wsum(hist_y_n);
	end

	assign warm_cnt_inc = warm_cnt_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
			end
			warm_cnt_q <= '0;
			warmed_q   <= 1'b0;
		end else if (step) begin
			hist_x_q <= hist_x_n;
			hist_y_q <= hist_y_n;
			if (!warmed_q) begin
				if (warm_cnt_inc == CNT_W'(WARMUP_ITEMS)) begin
					warmed_q   <= 1'b1;
					warm_cnt_q <= '0;
				end else begin
					warm_cnt_q <= warm_cnt_inc;
				end
			end
		end
	end

	// stage 2: weighted sums
	always_ff @(posedge clk) begin
		if (en2) begin
			sum_x_s2 <= sum_x_n;
			sum_y_s2 <= sum_y_n;
			tgt_s2   <= tgt_s1;
			cmd_s2   <= warmed_q;
		end
	end

	// stage 3: divide by 100
	always_ff @(posedge clk) begin
		if (en3) begin
			fx_s3  <= div100(sum_x_s2);
			fy_s3  <= div100(sum_y_s2);
			tgt_s3 <= tgt_s2;
			cmd_s3 <= cmd_s2;
		end
	end

	// stage 4: quadrant mapping
	always_ff @(posedge clk) begin
		if (en4) begin
			pos_s4 <= map_pos(fx_s3, fy_s3, bnd_lo_q, bnd_hi_q);
			fx_s4  <= fx_s3;
			fy_s4  <= fy_s3;
			tgt_s4 <= tgt_s3;
			cmd_s4 <= cmd_s3;
		end
	end

	// stage 5: command gate into the output register
	assign err     = ERR_W'(pos_s4) - ERR_W'(tgt_s4);
	assign err_abs = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
	assign near    = err_abs < ERR_W'(tol_q);

	always_ff @(posedge clk) begin
		if (en5) begin
			filtered_x    <= fx_s4;
			filtered_y    <= fy_s4;
			position      <= pos_s4;
			command_valid <= cmd_s4;
			at_target     <= cmd_s4 && near;
			motor_speed   <= (cmd_s4 && !near) ? speed_q : '0;
		end
	end

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_valid && !out_ready))
		else $error("input stalled while a pipeline stage is free");

	a_warm_count: assert property (@(posedge clk) disable iff (!arst_n)
		!warmed_q |-> (warm_cnt_q < CNT_W'(WARMUP_ITEMS)))
		else $error("warm-up count passed its limit");

	a_warm_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(warmed_q) |-> $past(step))
		else $error("warm-up finished without a request");

	a_stop_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && at_target) |-> (command_valid && (motor_speed == '0)))
		else $error("at target without a valid stop command");

	a_idle_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !command_valid) |-> (!at_target && (motor_speed == '0)))
		else $error("motor command issued during warm-up");

endmodule
